// ===== rtl/matrix_vector_multiply_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply block
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define MVM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define MVM_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MVM_ASSERT(name, clk, rst_n, prop, msg)
`define MVM_ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Shared widths, item types and control structs of the block.
// ----------------------------------------------------------------------------
package mvm_pkg;

  // Fixed field widths of the items.
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 2 * ELEM_W;
  localparam int unsigned SUM_W       = 42;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned CFG_W       = 11;

  // Default largest matrix dimension.
  localparam int unsigned MAX_DIM_DEF = 1024;

  // Output queue: power-of-two depth so the pointers wrap by themselves.
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W   = OUT_PTR_W + 1;

  // Meaning of the action field of an input item.
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_MATRIX = 1'b1
  } mvm_action_e;

  // Input item.
  typedef struct packed {
    mvm_action_e              action;
    logic signed [ELEM_W-1:0] value;
  } mvm_in_t;

  // Result item.
  typedef struct packed {
    logic signed [SUM_W-1:0] row_result;
    logic [ROW_W-1:0]        row_index;
    logic                    last_row;
  } mvm_out_t;

  // Control that travels with a matrix element through the pipeline.
  typedef struct packed {
    logic             first;
    logic             row_end;
    logic             last_row;
    logic [ROW_W-1:0] row_index;
  } mvm_tag_t;

endpackage

// ===== rtl/mvm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram
  import mvm_pkg::*;
#(
  parameter int unsigned WIDTH = ELEM_W,
  parameter int unsigned DEPTH = MAX_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply position control
// Holds the length, load, column and row positions and issues store accesses.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_top_assert.svh"

module mvm_ctrl
  import mvm_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF,
  localparam int unsigned IW     = $clog2(MAX_DIM)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             accept_i,
  input  mvm_action_e      action_i,
  output logic             ram_we_o,
  output logic [IW-1:0]    ram_waddr_o,
  output logic             ram_re_o,
  output logic [IW-1:0]    ram_raddr_o,
  output logic             issue_o,
  output mvm_tag_t         tag_o
);

  logic [IW-1:0] last_pos_q, last_pos_d;
  logic [IW-1:0] load_q, load_d;
  logic [IW-1:0] col_q, col_d;
  logic [IW-1:0] row_q, row_d;
  logic          fresh_q, fresh_d;
  logic          load_acc;
  logic          mat_acc;
  logic          col_end;
  logic          row_last;

  assign load_acc = accept_i && (action_i == ACT_LOAD);
  assign mat_acc  = accept_i && (action_i == ACT_MATRIX);
  assign col_end  = (col_q >= last_pos_q);
  assign row_last = (row_q >= last_pos_q);

  // Last valid position from the written length, clamped to 1..MAX_DIM.
  always_comb begin
    last_pos_d = last_pos_q;
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        last_pos_d = '0;
      end else if (32'(cfg_data_i) > 32'(MAX_DIM)) begin
        last_pos_d = IW'(MAX_DIM - 1);
      end else begin
        last_pos_d = IW'(cfg_data_i - CFG_W'(1));
      end
    end
  end

  // Position updates for loads and matrix elements.
  always_comb begin
    load_d  = load_q;
    col_d   = col_q;
    row_d   = row_q;
    fresh_d = fresh_q;
    if (load_acc) begin
      load_d = (load_q >= last_pos_q) ? '0 : IW'(load_q + IW'(1));
      if (load_q == '0) begin
        col_d   = '0;
        row_d   = '0;
        fresh_d = 1'b1;
      end
    end else if (mat_acc) begin
      if (col_end) begin
        col_d   = '0;
        row_d   = row_last ? '0 : IW'(row_q + IW'(1));
        fresh_d = 1'b1;
      end else begin
        col_d   = IW'(col_q + IW'(1));
        fresh_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= '0;
      load_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      fresh_q    <= 1'b1;
    end else begin
      last_pos_q <= last_pos_d;
      load_q     <= load_d;
      col_q      <= col_d;
      row_q      <= row_d;
      fresh_q    <= fresh_d;
    end
  end

  // Store accesses: loads write, matrix elements read their column.
  assign ram_we_o    = load_acc;
  assign ram_waddr_o = load_q;
  assign ram_re_o    = mat_acc;
  assign ram_raddr_o = col_q;

  // Tag for the multiply-accumulate pipeline.
  assign issue_o           = mat_acc;
  assign tag_o.first       = fresh_q;
  assign tag_o.row_end     = col_end;
  assign tag_o.last_row    = row_last;
  assign tag_o.row_index   = ROW_W'(row_q);

  // A load at position zero restarts the product.
  `MVM_ASSERT(a_load_restart, clk_i, rst_ni,
    load_acc && (load_q == '0) |=> (row_q == '0) && (col_q == '0) && fresh_q,
    "load at position zero did not restart the product")

  // The column position never runs past the clamped range.
  `MVM_ASSERT(a_col_range, clk_i, rst_ni,
    32'(col_q) < 32'(MAX_DIM),
    "column position out of range")

endmodule

// ===== rtl/mvm_mac.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply multiply-accumulate pipeline
// Multiplies each matrix element by its stored vector element and sums a row.
// ----------------------------------------------------------------------------
module mvm_mac
  import mvm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     issue_i,
  input  mvm_tag_t                 tag_i,
  input  logic signed [ELEM_W-1:0] value_i,
  input  logic [ELEM_W-1:0]        rdata_i,
  output logic                     push_o,
  output mvm_out_t                 push_item_o,
  output logic [1:0]               pend_o
);

  logic                     v1_q, v2_q;
  mvm_tag_t                 tag1_q, tag2_q;
  logic signed [ELEM_W-1:0] val1_q;
  logic signed [ELEM_W-1:0] vec_s;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  acc_q, acc_d;

  // Valid bits of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
    end
  end

  // Stage one holds the element while the store read completes.
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      tag1_q <= tag_i;
      val1_q <= value_i;
    end
  end

  // Stage two holds the product.
  assign vec_s  = $signed(rdata_i);
  assign prod_d = val1_q * vec_s;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      tag2_q <= tag1_q;
      prod_q <= prod_d;
    end
  end

  // Accumulate; the first element of a row starts from zero.
  assign prod_ext = {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = (tag2_q.first ? '0 : acc_q) + prod_ext;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  // Row result leaves with the last element of the row.
  assign push_o                 = v2_q && tag2_q.row_end;
  assign push_item_o.row_result = acc_d;
  assign push_item_o.row_index  = tag2_q.row_index;
  assign push_item_o.last_row   = tag2_q.last_row;

  // Results still inside the pipeline.
  assign pend_o = 2'(v1_q && tag1_q.row_end) + 2'(v2_q && tag2_q.row_end);

endmodule

// ===== rtl/mvm_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply output queue
// Small queue that holds row results until the downstream side takes them.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_top_assert.svh"

module mvm_out_fifo
  import mvm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mvm_out_t             push_item_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output mvm_out_t             item_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  mvm_out_t               mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   pop;

  assign pop = (cnt_q != '0) && !stall_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = OUT_CNT_W'(cnt_q + OUT_CNT_W'(1));
    end else if (pop && !push_i) begin
      cnt_d = OUT_CNT_W'(cnt_q - OUT_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= OUT_PTR_W'(wr_ptr_q + OUT_PTR_W'(1));
      end
      if (pop) begin
        rd_ptr_q <= OUT_PTR_W'(rd_ptr_q + OUT_PTR_W'(1));
      end
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // The input stall must keep the queue from overflowing.
  `MVM_ASSERT_NEVER(a_push_full, clk_i, rst_ni,
    push_i && (32'(cnt_q) >= 32'(OUT_DEPTH)) && !pop,
    "row result pushed into a full output queue")

  // Occupancy stays within the depth.
  `MVM_ASSERT(a_cnt_range, clk_i, rst_ni,
    32'(cnt_q) <= 32'(OUT_DEPTH),
    "output queue occupancy beyond its depth")

endmodule

// ===== rtl/matrix_vector_multiply_top.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply top level
// Computes y = A * x: vector elements go to a store, matrix elements stream
// in row-major order and each row gives one exact Q26.16 dot product.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  mvm_in_t (action, value)
//   out      output     out_valid_o/out_stall_i mvm_out_t (row_result, row_index,
//                                              last_row)
//   cfg      input      cfg_valid_i/cfg_ready_o vector_length, 11 bits
//
// One item is accepted per cycle while in_stall_o is low, loads and matrix elements alike.
// A matrix element goes through store read, multiply and accumulate; a row
// result is written into the output queue once its last element has passed
// stage one and stage two, and can then leave the queue.
// The output queue holds four results; the input stalls while the queue plus
// the results still in the pipeline would fill it.
// Reset clears the positions and the length (to one); the vector store is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top
  import mvm_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mvm_in_t          in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mvm_out_t         out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_DIM);

  logic                 accept;
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [IW-1:0]        ram_raddr;
  logic [ELEM_W-1:0]    ram_rdata;
  logic                 issue;
  mvm_tag_t             tag;
  logic                 push;
  mvm_out_t             push_item;
  logic [1:0]           pend;
  logic [OUT_CNT_W-1:0] count;
  logic [OUT_CNT_W:0]   occupancy;

  // Input stall from registered occupancy only.
  assign occupancy  = (OUT_CNT_W + 1)'(count) + (OUT_CNT_W + 1)'(pend);
  assign in_stall_o = (occupancy >= (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // The length register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  mvm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .action_i    (in_item_i.action),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .issue_o     (issue),
    .tag_o       (tag)
  );

  // Vector store.
  mvm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_item_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mvm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .tag_i       (tag),
    .value_i     (in_item_i.value),
    .rdata_i     (ram_rdata),
    .push_o      (push),
    .push_item_o (push_item),
    .pend_o      (pend)
  );

  mvm_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .item_o      (out_item_o),
    .count_o     (count)
  );

endmodule
